@@ rtl/es2c_pkg.sv @@
package es2c_pkg;

	// Constant divisors share one remainder width; the 400-year day count is the widest.
	localparam int DIV_BITS = 18;
	// A time of day is below 86400, so it fits in 17 bits.
	localparam int TOD_BITS = 17;

	localparam logic [DIV_BITS-1:0] SECS_PER_DAY  = 18'd86400;
	localparam logic [DIV_BITS-1:0] SECS_PER_HOUR = 18'd3600;
	localparam logic [DIV_BITS-1:0] SECS_PER_MIN  = 18'd60;
	localparam logic [DIV_BITS-1:0] DAYS_YEAR     = 18'd365;
	localparam logic [DIV_BITS-1:0] DAYS_4Y       = 18'd1461;
	localparam logic [DIV_BITS-1:0] DAYS_100Y     = 18'd36524;
	localparam logic [DIV_BITS-1:0] DAYS_400Y     = 18'd146097;
	localparam logic [DIV_BITS-1:0] DAYS_WEEK     = 18'd7;

	// Days from 1601-01-01 to 1970-01-01.
	localparam int SHIFT_1601    = 134774;
	// A year counted from March 1st: one year ahead, less January and February, plus one.
	localparam int LEAP_DAY_SHIFT = 307;
	// Years from 1601 back to 1900 in the 1601-relative count.
	localparam int YEAR_1601_REL = 299;

	typedef enum logic [3:0] {
		OP_SECS,
		OP_TOD,
		OP_MIN,
		OP_LD_Q,
		OP_LD_C,
		OP_LD_Y,
		OP_LY_Q,
		OP_LY_C,
		OP_LY_Y,
		OP_YEAR,
		OP_WDAY
	} es2c_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LAUNCH,
		ST_WAIT,
		ST_FINISH
	} es2c_state_t;

	typedef struct packed {
		logic     load;
		logic     start;
		logic     capture;
		logic     finish;
		es2c_op_t op;
	} es2c_cmd_t;

	typedef struct packed {
		logic div_done;
	} es2c_stat_t;

	// First day of year of each month, with month 12 marking the end of the year.
	function automatic logic [8:0] month_start(input logic leap, input logic [3:0] m);
		logic [8:0] base;
		unique case (m)
			4'd0:    base = 9'd0;
			4'd1:    base = 9'd31;
			4'd2:    base = 9'd59;
			4'd3:    base = 9'd90;
			4'd4:    base = 9'd120;
			4'd5:    base = 9'd151;
			4'd6:    base = 9'd181;
			4'd7:    base = 9'd212;
			4'd8:    base = 9'd243;
			4'd9:    base = 9'd273;
			4'd10:   base = 9'd304;
			4'd11:   base = 9'd334;
			4'd12:   base = 9'd365;
			default: base = 9'd0;
		endcase
		if (leap && m >= 4'd2) begin
			month_start = base + 9'd1;
		end else begin
			month_start = base;
		end
	endfunction

endpackage

@@ rtl/epoch_seconds_to_calendar.sv @@
// One transaction is taken at a time: the input stalls while the single
// reciprocal-multiply divider performs all eleven constant divisions in turn, until the
// result is written to the output register.
// A finished result waits in an output register while the next transaction is taken;
// a result still held by the receiver delays the next one until it has gone.
// Reset (arst_n, asynchronous, active low) clears the controller and the output valid.
module epoch_seconds_to_calendar import es2c_pkg::*; #(
	parameter int SECONDS_BITS = 38
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [SECONDS_BITS-1:0] epoch_seconds,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [5:0]              second,
	output logic [5:0]              minute,
	output logic [4:0]              hour,
	output logic [4:0]              month_day,
	output logic [3:0]              month,
	output logic [13:0]             year_since_1900,
	output logic [2:0]              week_day,
	output logic [8:0]              year_day
);

	es2c_cmd_t  cmd;
	es2c_stat_t status;

	es2c_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status   (status),
		.cmd      (cmd)
	);

	es2c_dp #(
		.SECONDS_BITS(SECONDS_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.epoch_seconds  (epoch_seconds),
		.second         (second),
		.minute         (minute),
		.hour           (hour),
		.month_day      (month_day),
		.month          (month),
		.year_since_1900(year_since_1900),
		.week_day       (week_day),
		.year_day       (year_day)
	);

endmodule

@@ rtl/es2c_div.sv @@
module es2c_div import es2c_pkg::*; #(
	parameter int WIDTH    = 38,
	parameter int RCP_BITS = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [WIDTH-1:0]             dividend,
	input  logic [DIV_BITS-1:0]          divisor,
	input  logic [RCP_BITS-1:0]          recip,
	input  logic [$clog2(WIDTH+1)-1:0]   shift,
	output logic                         done,
	output logic [WIDTH-1:0]             quotient,
	output logic [DIV_BITS-1:0]          remainder
);

	localparam int SH_BITS   = $clog2(WIDTH+1);
	localparam int LO_BITS   = WIDTH / 2;
	localparam int HI_BITS   = WIDTH - LO_BITS;
	localparam int PROD_BITS = WIDTH + RCP_BITS;
	// Twice the largest divisor still fits, so the first remainder needs one bit more.
	localparam int REM_BITS  = DIV_BITS + 1;

	logic [4:0]                  step_q;
	logic                        done_q;
	logic [WIDTH-1:0]            num_q;
	logic [RCP_BITS-1:0]         rcp_q;
	logic [DIV_BITS-1:0]         div_q;
	logic [SH_BITS-1:0]          sh_q;
	logic [PROD_BITS-1:0]        prod_q;
	logic [WIDTH-1:0]            quo_q;
	logic [REM_BITS-1:0]         rem_q;
	logic [LO_BITS+RCP_BITS-1:0] part_lo;
	logic [HI_BITS+RCP_BITS-1:0] part_hi;
	logic [REM_BITS+DIV_BITS-1:0] back;
	logic [REM_BITS-1:0]         rem_est;
	logic                        fits;

	// The reciprocal is rounded down, so the first quotient is exact or one too small.
	assign part_lo = num_q[LO_BITS-1:0] * rcp_q;
	assign part_hi = num_q[WIDTH-1:LO_BITS] * rcp_q;
	assign back    = quo_q[REM_BITS-1:0] * div_q;
	assign rem_est = num_q[REM_BITS-1:0] - back[REM_BITS-1:0];
	assign fits    = rem_q >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= step_q[4];
			if (start) begin
				step_q <= 5'b00001;
			end else begin
				step_q <= {step_q[3:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rcp_q <= recip;
			div_q <= divisor;
			sh_q  <= shift;
		end else if (step_q[0]) begin
			prod_q <= PROD_BITS'(part_lo);
		end else if (step_q[1]) begin
			prod_q <= prod_q + {part_hi, {LO_BITS{1'b0}}};
		end else if (step_q[2]) begin
			quo_q <= WIDTH'(prod_q >> sh_q);
		end else if (step_q[3]) begin
			rem_q <= rem_est;
		end else if (step_q[4] && fits) begin
			quo_q <= quo_q + WIDTH'(1);
			rem_q <= rem_q - {1'b0, div_q};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q[DIV_BITS-1:0];

endmodule

@@ rtl/es2c_dp.sv @@
module es2c_dp import es2c_pkg::*; #(
	parameter int SECONDS_BITS = 38
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  es2c_cmd_t               cmd,
	output es2c_stat_t              status,
	input  logic [SECONDS_BITS-1:0] epoch_seconds,
	output logic [5:0]              second,
	output logic [5:0]              minute,
	output logic [4:0]              hour,
	output logic [4:0]              month_day,
	output logic [3:0]              month,
	output logic [13:0]             year_since_1900,
	output logic [2:0]              week_day,
	output logic [8:0]              year_day
);

	localparam int DAY_BITS = SECONDS_BITS - 14;
	localparam int SH_BITS  = $clog2(SECONDS_BITS+1);

	// Reciprocals scaled by the largest dividend each division can see, rounded down.
	localparam logic [DAY_BITS-1:0] RCP_DAY  =
		DAY_BITS'((64'd1 << SECONDS_BITS) / 64'(SECS_PER_DAY));
	localparam logic [DAY_BITS-1:0] RCP_HOUR =
		DAY_BITS'((64'd1 << TOD_BITS) / 64'(SECS_PER_HOUR));
	localparam logic [DAY_BITS-1:0] RCP_MIN  =
		DAY_BITS'((64'd1 << TOD_BITS) / 64'(SECS_PER_MIN));
	localparam logic [DAY_BITS-1:0] RCP_400Y =
		DAY_BITS'((64'd1 << DAY_BITS) / 64'(DAYS_400Y));
	localparam logic [DAY_BITS-1:0] RCP_100Y =
		DAY_BITS'((64'd1 << DAY_BITS) / 64'(DAYS_100Y));
	localparam logic [DAY_BITS-1:0] RCP_4Y   =
		DAY_BITS'((64'd1 << DAY_BITS) / 64'(DAYS_4Y));
	localparam logic [DAY_BITS-1:0] RCP_YEAR =
		DAY_BITS'((64'd1 << DAY_BITS) / 64'(DAYS_YEAR));
	localparam logic [DAY_BITS-1:0] RCP_WEEK =
		DAY_BITS'((64'd1 << DAY_BITS) / 64'(DAYS_WEEK));

	typedef enum logic [1:0] {
		CLS_FULL,
		CLS_TOD,
		CLS_DAY
	} width_cls_t;

	logic [SECONDS_BITS-1:0] secs_q;
	logic [DAY_BITS-1:0]     days_q;
	logic [TOD_BITS-1:0]     tod_q;
	logic [11:0]             mrem_q;
	logic [4:0]              hour_q;
	logic [5:0]              min_q;
	logic [5:0]              sec_q;
	logic [DAY_BITS-1:0]     work_q;
	logic [DAY_BITS-1:0]     q400_q;
	logic [DAY_BITS-1:0]     c100_q;
	logic [DAY_BITS-1:0]     ldays_q;
	logic [DAY_BITS-1:0]     lyears_q;
	logic [DAY_BITS-1:0]     years_q;
	logic [8:0]              yrem_q;
	logic [2:0]              wday_q;

	width_cls_t              cls;
	logic [TOD_BITS-1:0]     tod_opnd;
	logic [DAY_BITS-1:0]     day_opnd;
	logic [SECONDS_BITS-1:0] dividend;
	logic [DIV_BITS-1:0]     divisor;
	logic [DAY_BITS-1:0]     recip;
	logic [SH_BITS-1:0]      shift;
	logic                    div_done;
	logic [SECONDS_BITS-1:0] quotient;
	logic [DIV_BITS-1:0]     remainder;
	logic [DAY_BITS-1:0]     quot_day;

	logic                    leap;
	logic [8:0]              yday;
	logic [3:0]              mon;
	logic [8:0]              mday_off;
	logic [DAY_BITS-1:0]     yr_rel;

	always_comb begin
		cls      = CLS_DAY;
		tod_opnd = tod_q;
		day_opnd = days_q;
		divisor  = DAYS_YEAR;
		recip    = RCP_YEAR;
		unique case (cmd.op)
			OP_SECS: begin
				cls     = CLS_FULL;
				divisor = SECS_PER_DAY;
				recip   = RCP_DAY;
			end
			OP_TOD: begin
				cls     = CLS_TOD;
				divisor = SECS_PER_HOUR;
				recip   = RCP_HOUR;
			end
			OP_MIN: begin
				cls      = CLS_TOD;
				tod_opnd = TOD_BITS'(mrem_q);
				divisor  = SECS_PER_MIN;
				recip    = RCP_MIN;
			end
			OP_LD_Q: begin
				day_opnd = days_q + DAY_BITS'(LEAP_DAY_SHIFT);
				divisor  = DAYS_400Y;
				recip    = RCP_400Y;
			end
			OP_LD_C, OP_LY_C: begin
				day_opnd = work_q;
				divisor  = DAYS_100Y;
				recip    = RCP_100Y;
			end
			OP_LD_Y, OP_LY_Y: begin
				day_opnd = work_q;
				divisor  = DAYS_4Y;
				recip    = RCP_4Y;
			end
			OP_LY_Q: begin
				day_opnd = days_q;
				divisor  = DAYS_400Y;
				recip    = RCP_400Y;
			end
			OP_YEAR: begin
				day_opnd = days_q - ldays_q;
				divisor  = DAYS_YEAR;
				recip    = RCP_YEAR;
			end
			OP_WDAY: begin
				day_opnd = days_q + DAY_BITS'(1);
				divisor  = DAYS_WEEK;
				recip    = RCP_WEEK;
			end
			default: begin
				day_opnd = days_q;
			end
		endcase
	end

	always_comb begin
		unique case (cls)
			CLS_FULL: begin
				dividend = secs_q;
				shift    = SH_BITS'(SECONDS_BITS);
			end
			CLS_TOD: begin
				dividend = SECONDS_BITS'(tod_opnd);
				shift    = SH_BITS'(TOD_BITS);
			end
			default: begin
				dividend = SECONDS_BITS'(day_opnd);
				shift    = SH_BITS'(DAY_BITS);
			end
		endcase
	end

	es2c_div #(
		.WIDTH   (SECONDS_BITS),
		.RCP_BITS(DAY_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.start),
		.dividend (dividend),
		.divisor  (divisor),
		.recip    (recip),
		.shift    (shift),
		.done     (div_done),
		.quotient (quotient),
		.remainder(remainder)
	);

	assign status.div_done = div_done;
	assign quot_day        = quotient[DAY_BITS-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			secs_q <= epoch_seconds;
		end
		if (cmd.capture) begin
			unique case (cmd.op)
				OP_SECS: begin
					days_q <= quot_day + DAY_BITS'(SHIFT_1601);
					tod_q  <= remainder[TOD_BITS-1:0];
				end
				OP_TOD: begin
					hour_q <= quotient[4:0];
					mrem_q <= remainder[11:0];
				end
				OP_MIN: begin
					min_q <= quotient[5:0];
					sec_q <= remainder[5:0];
				end
				OP_LD_Q, OP_LY_Q: begin
					q400_q <= quot_day;
					work_q <= day_opnd - quot_day;
				end
				OP_LD_C, OP_LY_C: begin
					c100_q <= quot_day;
					work_q <= work_q + quot_day;
				end
				OP_LD_Y: begin
					ldays_q <= quot_day - c100_q + q400_q;
				end
				OP_LY_Y: begin
					lyears_q <= quot_day - c100_q + q400_q;
				end
				OP_YEAR: begin
					years_q <= quot_day;
					yrem_q  <= remainder[8:0];
				end
				OP_WDAY: begin
					wday_q <= remainder[2:0];
				end
				default: begin
				end
			endcase
		end
	end

	// The year is a leap year when a leap day lies between its start and the next March.
	assign leap   = ldays_q != lyears_q;
	assign yday   = yrem_q + {8'd0, leap};
	assign yr_rel = years_q - DAY_BITS'(YEAR_1601_REL);

	always_comb begin
		mon = 4'd0;
		for (int k = 1; k < 12; k++) begin
			if (yday >= month_start(leap, 4'(k))) begin
				mon = 4'(k);
			end
		end
	end

	assign mday_off = yday - month_start(leap, mon) + 9'd1;

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			second          <= sec_q;
			minute          <= min_q;
			hour            <= hour_q;
			month_day       <= mday_off[4:0];
			month           <= mon;
			year_since_1900 <= yr_rel[13:0];
			week_day        <= wday_q;
			year_day        <= yday;
		end
	end

endmodule

@@ rtl/es2c_ctrl.sv @@
module es2c_ctrl import es2c_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	input  es2c_stat_t status,
	output es2c_cmd_t  cmd
);

	es2c_state_t state_q, state_d;
	es2c_op_t    op_q, op_d, op_next;
	logic        out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_SECS;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			op_q        <= op_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		unique case (op_q)
			OP_SECS: op_next = OP_TOD;
			OP_TOD:  op_next = OP_MIN;
			OP_MIN:  op_next = OP_LD_Q;
			OP_LD_Q: op_next = OP_LD_C;
			OP_LD_C: op_next = OP_LD_Y;
			OP_LD_Y: op_next = OP_LY_Q;
			OP_LY_Q: op_next = OP_LY_C;
			OP_LY_C: op_next = OP_LY_Y;
			OP_LY_Y: op_next = OP_YEAR;
			OP_YEAR: op_next = OP_WDAY;
			default: op_next = OP_SECS;
		endcase
	end

	always_comb begin
		state_d     = state_q;
		op_d        = op_q;
		cmd         = '0;
		cmd.op      = op_q;
		in_stall    = state_q != ST_IDLE;
		out_valid_d = out_valid_q && out_stall;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					op_d     = OP_SECS;
					state_d  = ST_LAUNCH;
				end
			end
			ST_LAUNCH: begin
				cmd.start = 1'b1;
				state_d   = ST_WAIT;
			end
			ST_WAIT: begin
				if (status.div_done) begin
					cmd.capture = 1'b1;
					if (op_q == OP_WDAY) begin
						state_d = ST_FINISH;
					end else begin
						op_d    = op_next;
						state_d = ST_LAUNCH;
					end
				end
			end
			ST_FINISH: begin
				// The result register may only be overwritten once its transaction has gone.
				if (!out_valid_q || !out_stall) begin
					cmd.finish  = 1'b1;
					out_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

@@ bench/calendar_checker.sv @@
module calendar_checker #(
	parameter int SECONDS_BITS = 38
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_stall,
	input  logic [SECONDS_BITS-1:0] epoch_seconds,
	input  logic                    out_valid,
	input  logic                    out_stall,
	input  logic [5:0]              second,
	input  logic [5:0]              minute,
	input  logic [4:0]              hour,
	input  logic [4:0]              month_day,
	input  logic [3:0]              month,
	input  logic [13:0]             year_since_1900,
	input  logic [2:0]              week_day,
	input  logic [8:0]              year_day,
	output int unsigned             error_count,
	output int unsigned             pending_count,
	output int unsigned             checked_count
);

	localparam longint unsigned DAY_SECS       = 86400;
	localparam longint unsigned HOUR_SECS      = 3600;
	localparam longint unsigned YEAR_DAYS      = 365;
	localparam longint unsigned QUAD_DAYS      = 1461;
	localparam longint unsigned CENTURY_DAYS   = 36524;
	localparam longint unsigned QUAD_CENT_DAYS = 146097;
	// Days from 1601-01-01, the start of a 400-year cycle, to 1970-01-01.
	localparam longint unsigned DAYS_1601_1970 = 134774;
	// Counting from March 1st moves a leap day to the end of its year.
	localparam longint unsigned FROM_MARCH     = 307;
	localparam longint unsigned YEARS_1601_1900 = 299;

	localparam int unsigned COMMON_STARTS [13] = '{0, 31, 59, 90, 120, 151, 181, 212, 243,
		273, 304, 334, 365};
	localparam int unsigned LEAP_STARTS [13] = '{0, 31, 60, 91, 121, 152, 182, 213, 244,
		274, 305, 335, 366};

	typedef struct packed {
		logic [SECONDS_BITS-1:0] stamp;
		logic [5:0]              second;
		logic [5:0]              minute;
		logic [4:0]              hour;
		logic [4:0]              month_day;
		logic [3:0]              month;
		logic [13:0]             year_since_1900;
		logic [2:0]              week_day;
		logic [8:0]              year_day;
	} calendar_t;

	calendar_t awaited_dates [$];

	// Leap years completed within d days counted from 1601-01-01.
	function automatic longint unsigned leap_years_in(input longint unsigned d);
		longint unsigned cycles;
		longint unsigned centuries;
		longint unsigned rest;
		cycles    = d / QUAD_CENT_DAYS;
		rest      = d - cycles;
		centuries = rest / CENTURY_DAYS;
		rest      = rest + centuries;
		return rest / QUAD_DAYS - centuries + cycles;
	endfunction

	function automatic int unsigned month_first_day(input logic leap, input int unsigned m);
		return leap ? LEAP_STARTS[m] : COMMON_STARTS[m];
	endfunction

	function automatic calendar_t to_calendar(input logic [SECONDS_BITS-1:0] stamp);
		longint unsigned secs;
		longint unsigned tod;
		longint unsigned days;
		longint unsigned feb29_passed;
		longint unsigned full_leaps;
		longint unsigned years;
		longint unsigned yday;
		logic            leap;
		int unsigned     m;
		calendar_t       date;
		secs         = 64'(stamp);
		tod          = secs % DAY_SECS;
		days         = secs / DAY_SECS + DAYS_1601_1970;
		feb29_passed = leap_years_in(days + FROM_MARCH);
		full_leaps   = leap_years_in(days);
		years        = (days - feb29_passed) / YEAR_DAYS;
		yday         = days - years * YEAR_DAYS - full_leaps;
		// A leap day already counted for this year, but not its leap year, marks a leap year.
		leap         = feb29_passed > full_leaps;
		m = 0;
		while (m < 11 && yday >= month_first_day(leap, m + 1))
			m++;
		date.stamp           = stamp;
		date.second          = 6'((tod % HOUR_SECS) % 60);
		date.minute          = 6'((tod % HOUR_SECS) / 60);
		date.hour            = 5'(tod / HOUR_SECS);
		date.month_day       = 5'(1 + yday - month_first_day(leap, m));
		date.month           = 4'(m);
		date.year_since_1900 = 14'(years - YEARS_1601_1900);
		date.week_day        = 3'((days + 1) % 7);
		date.year_day        = 9'(yday);
		return date;
	endfunction

	task automatic check_field(input string label, input longint unsigned want,
		input longint unsigned got, input logic [SECONDS_BITS-1:0] stamp);
		if (want != got) begin
			$display("%0t: %s for epoch_seconds %0d: expected %0d, actual %0d",
				$time, label, stamp, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		calendar_t want;
		if (!arst_n) begin
			awaited_dates.delete();
			error_count   = 0;
			checked_count = 0;
		end else begin
			if (in_valid && !in_stall)
				awaited_dates.push_back(to_calendar(epoch_seconds));
			if (out_valid && !out_stall) begin
				if (awaited_dates.size() == 0) begin
					$display("%0t: result transaction with none expected, expected nothing, actual %0d",
						$time, year_since_1900);
					error_count++;
				end else begin
					want = awaited_dates.pop_front();
					check_field("second", want.second, second, want.stamp);
					check_field("minute", want.minute, minute, want.stamp);
					check_field("hour", want.hour, hour, want.stamp);
					check_field("month_day", want.month_day, month_day, want.stamp);
					check_field("month", want.month, month, want.stamp);
					check_field("year_since_1900", want.year_since_1900, year_since_1900,
						want.stamp);
					check_field("week_day", want.week_day, week_day, want.stamp);
					check_field("year_day", want.year_day, year_day, want.stamp);
					checked_count++;
				end
			end
		end
		pending_count = awaited_dates.size();
	end

endmodule

@@ bench/tb.sv @@
module tb;

	localparam int SECONDS_BITS   = 38;
	localparam int IDLE_PCT       = 38;
	localparam int RANDOM_ITEMS   = 2000;
	localparam int HOLD_START     = 30000;
	localparam int HOLD_CYCLES    = 1200;
	localparam int CALM_FROM      = 76000;
	localparam int CALM_TO        = 100000;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 300;

	localparam longint unsigned STAMP_MASK = (64'd1 << SECONDS_BITS) - 1;
	localparam longint unsigned DAY_SECS   = 86400;
	localparam int unsigned     LAST_DAY   = 32'(STAMP_MASK / DAY_SECS);
	// Years divisible by four from 1972 that still fit below the top of the input range.
	localparam int unsigned     LAST_QUAD  = 2176;

	localparam longint unsigned BOUNDARY_STAMPS [21] = '{
		64'd0,              // the epoch itself
		64'd59,
		64'd3599,
		64'd3600,
		64'd86399,          // last second of the first day
		64'd86400,
		64'd31535999,       // end of 1970
		64'd951782400,      // start of 29 February 2000
		64'd951868799,      // end of 29 February 2000
		64'd978307199,      // end of the leap year 2000
		64'd2147483647,
		64'd2147483648,
		64'd4107542399,     // end of 28 February 2100, not a leap year
		64'd4107542400,     // 1 March 2100
		64'd4294967295,
		64'd4294967296,
		64'd13574563200,    // 29 February 2400
		64'h2A_AAAA_AAAA,
		64'h15_5555_5555,
		64'h20_0000_0000,
		STAMP_MASK          // largest input
	};

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_stall;
	logic [SECONDS_BITS-1:0] epoch_seconds;
	logic                    out_valid;
	logic                    out_stall;
	logic [5:0]              second;
	logic [5:0]              minute;
	logic [4:0]              hour;
	logic [4:0]              month_day;
	logic [3:0]              month;
	logic [13:0]             year_since_1900;
	logic [2:0]              week_day;
	logic [8:0]              year_day;
	int unsigned             error_count;
	int unsigned             pending_count;
	int unsigned             checked_count;
	int                      sender_idle_pct;

	epoch_seconds_to_calendar #(
		.SECONDS_BITS(SECONDS_BITS)
	) u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.epoch_seconds  (epoch_seconds),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.second         (second),
		.minute         (minute),
		.hour           (hour),
		.month_day      (month_day),
		.month          (month),
		.year_since_1900(year_since_1900),
		.week_day       (week_day),
		.year_day       (year_day)
	);

	calendar_checker #(
		.SECONDS_BITS(SECONDS_BITS)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.epoch_seconds  (epoch_seconds),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.second         (second),
		.minute         (minute),
		.hour           (hour),
		.month_day      (month_day),
		.month          (month),
		.year_since_1900(year_since_1900),
		.week_day       (week_day),
		.year_day       (year_day),
		.error_count    (error_count),
		.pending_count  (pending_count),
		.checked_count  (checked_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Picks a timestamp: anywhere in range, within 32 bits, at a day edge, or on the
	// last days of February in some year divisible by four.
	function automatic longint unsigned random_stamp();
		longint unsigned stamp;
		longint unsigned days;
		int unsigned     year;
		case ($urandom_range(3))
			0: stamp = {$urandom(), $urandom()} & STAMP_MASK;
			1: stamp = 64'($urandom());
			2: stamp = 64'($urandom_range(LAST_DAY - 1)) * DAY_SECS
				+ ($urandom_range(1) ? 64'd86399 : 64'd0);
			default: begin
				year = 1972 + 4 * $urandom_range(LAST_QUAD);
				days = 365 * 64'(year - 1970) + (year - 1) / 4 - (year - 1) / 100
					+ (year - 1) / 400 - 477;
				// Day 59 is 29 February in a leap year and 1 March in a century year.
				days = days + 59 - $urandom_range(1);
				stamp = days * DAY_SECS + $urandom_range(86399);
			end
		endcase
		return stamp;
	endfunction

	task automatic offer(input longint unsigned stamp);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		epoch_seconds <= stamp[SECONDS_BITS-1:0];
		do
			@(posedge clk);
		while (in_stall);
	endtask

	// The receiver holds off once for long enough that the block backs up and stalls
	// its input, and later takes every result at once for a long stretch.
	initial begin : receiver
		int unsigned cycle;
		out_stall = 1'b0;
		cycle     = 0;
		forever begin
			@(posedge clk);
			cycle++;
			if (cycle >= HOLD_START && cycle < HOLD_START + HOLD_CYCLES)
				out_stall <= 1'b1;
			else if (cycle >= CALM_FROM && cycle < CALM_TO)
				out_stall <= 1'b0;
			else
				out_stall <= ($urandom_range(99) < IDLE_PCT);
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb: no transaction for %0d cycles", quiet);
		$display("tb: done, errors");
		$finish;
	end

	initial begin : stimulus
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		epoch_seconds   = '0;
		sender_idle_pct = IDLE_PCT;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		foreach (BOUNDARY_STAMPS[i])
			offer(BOUNDARY_STAMPS[i]);
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			sender_idle_pct = (n >= 900 && n < 1250) ? 0 : IDLE_PCT;
			offer(random_stamp());
		end
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_count != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("tb: %0d timestamps converted and checked, from the epoch to the top of the %0d-bit range,",
			checked_count, SECONDS_BITS);
		$display("tb: with day edges, leap days, century years and a %0d-cycle receiver hold-off",
			HOLD_CYCLES);
		if (error_count == 0 && pending_count == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule
